### hw/rtl/ctns_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctns_pkg
// shared types, constants and the micro-op program of the coplanarity solver
// ----------------------------------------------------------------------------
package ctns_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int COORD_W         = 32;
   localparam int TIME_W          = 32;
   localparam int THR_W           = 32;
   localparam int LIM_W           = 5;
   localparam int MAX_ITER        = 16;
   localparam int NUM_DIFF        = 18;
   localparam int NUM_LOAD        = NUM_DIFF + 1;
   localparam int WORD_W          = 64;
   localparam int RF_DEPTH        = 32;
   localparam int RF_AW           = $clog2(RF_DEPTH);
   localparam int QUEUE_DEPTH     = 2;
   localparam int REQ_DATA_W      = 7 * COORD_W;
   localparam int RSP_DATA_W      = 40;
   localparam int CSR_IDX_W       = 1;
   localparam int CSR_DATA_W      = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_FLAT_THRESHOLD  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ITERATION_LIMIT = 1'd1;
   localparam logic [THR_W-1:0]     FLAT_THRESHOLD_RST  = 32'd1;
   localparam logic [LIM_W-1:0]     ITERATION_LIMIT_RST = 5'd10;

   localparam logic [1:0] SLOT_SOLVE = 2'd3;

   // register file map
   localparam logic [RF_AW-1:0] ADDR_T  = 5'd18;
   localparam logic [RF_AW-1:0] ADDR_T0 = 5'd19;
   localparam logic [RF_AW-1:0] ADDR_T1 = 5'd20;
   localparam logic [RF_AW-1:0] ADDR_T2 = 5'd21;
   localparam logic [RF_AW-1:0] ADDR_T3 = 5'd22;
   localparam logic [RF_AW-1:0] ADDR_T4 = 5'd23;
   localparam logic [RF_AW-1:0] ADDR_R0 = 5'd24;
   localparam logic [RF_AW-1:0] ADDR_A0 = 5'd24;
   localparam logic [RF_AW-1:0] ADDR_A1 = 5'd25;
   localparam logic [RF_AW-1:0] ADDR_R2 = 5'd26;
   localparam logic [RF_AW-1:0] ADDR_R3 = 5'd27;
   localparam logic [RF_AW-1:0] ADDR_A2 = 5'd28;
   localparam logic [RF_AW-1:0] ADDR_R5 = 5'd29;
   localparam logic [RF_AW-1:0] ADDR_R6 = 5'd30;
   localparam logic [RF_AW-1:0] ADDR_A3 = 5'd31;

   localparam logic [3:0] TRIPLE_LAST  = 4'd13;
   localparam logic [3:0] COMBINE_LAST = 4'd3;
   localparam logic [3:0] NEWTON_FD    = 4'd6;
   localparam logic [3:0] NEWTON_LAST  = 4'd12;
   localparam logic [2:0] TRIPLE_MAX   = 3'd7;
   localparam logic [4:0] LOAD_LAST    = 5'(NUM_LOAD - 1);
   localparam logic [5:0] DIV_STEPS    = 6'd33;

   localparam logic signed [63:0] SMAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [64:0] SMAX65 = {1'b0, SMAX};
   localparam logic signed [64:0] NMAX65 = -SMAX65;

   typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL16, OP_MUL28} opcode_type;
   typedef enum logic [1:0] {PH_TRIPLE, PH_COMBINE, PH_NEWTON} phase_type;
   typedef enum logic [1:0] {ST_CONVERGED, ST_FLAT, ST_LIMIT} status_type;
   typedef enum logic [3:0] {
      S_IDLE, S_LOAD, S_FETCH, S_EXEC, S_MUL, S_MWR, S_CHK, S_DIVI, S_DIV, S_UPD, S_DONE
   } back_state_type;

   typedef struct packed {
      opcode_type       op;
      logic [RF_AW-1:0] dst;
      logic [RF_AW-1:0] sa;
      logic [RF_AW-1:0] sb;
   } uop_type;

   typedef struct packed {
      logic                     hit;
      status_type               status;
      logic signed [TIME_W-1:0] refined_time;
   } result_type;

   function automatic logic signed [63:0] sat65(input logic signed [64:0] v);
      if (v > SMAX65) return SMAX;
      if (v < NMAX65) return -SMAX;
      return v[63:0];
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] v);
      return v[63] ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic is_flat(input logic signed [63:0] v,
                                    input logic [THR_W-1:0] thr);
      return (v == 64'sd0) || (mag64(v) < {32'd0, thr});
   endfunction

   // which operands of a triple product come from the velocity differences
   function automatic logic [2:0] tri_mask(input logic [2:0] idx);
      logic [2:0] m;
      case (idx)
         3'd0:    m = 3'b000;
         3'd1:    m = 3'b001;
         3'd2:    m = 3'b010;
         3'd3:    m = 3'b100;
         3'd4:    m = 3'b011;
         3'd5:    m = 3'b101;
         3'd6:    m = 3'b110;
         default: m = 3'b111;
      endcase
      return m;
   endfunction

   function automatic logic [RF_AW-1:0] vec_addr(input logic is_v, input logic [1:0] k,
                                                 input logic [1:0] axis);
      return (is_v ? 5'd9 : 5'd0) + 5'(k) * 5'd3 + 5'(axis);
   endfunction

   function automatic uop_type mk(input opcode_type op, input logic [RF_AW-1:0] d,
                                  input logic [RF_AW-1:0] a, input logic [RF_AW-1:0] b);
      uop_type u;
      u.op  = op;
      u.dst = d;
      u.sa  = a;
      u.sb  = b;
      return u;
   endfunction

   function automatic uop_type prog(input phase_type ph, input logic [2:0] tri_idx,
                                    input logic [3:0] step);
      uop_type          u;
      logic [2:0]       m;
      logic [RF_AW-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2, rd;
      m  = tri_mask(tri_idx);
      a0 = vec_addr(m[0], 2'd0, 2'd0);
      a1 = vec_addr(m[0], 2'd0, 2'd1);
      a2 = vec_addr(m[0], 2'd0, 2'd2);
      b0 = vec_addr(m[1], 2'd1, 2'd0);
      b1 = vec_addr(m[1], 2'd1, 2'd1);
      b2 = vec_addr(m[1], 2'd1, 2'd2);
      c0 = vec_addr(m[2], 2'd2, 2'd0);
      c1 = vec_addr(m[2], 2'd2, 2'd1);
      c2 = vec_addr(m[2], 2'd2, 2'd2);
      rd = ADDR_R0 + 5'(tri_idx);
      u  = mk(OP_ADD, ADDR_T0, ADDR_T0, ADDR_T0);
      case (ph)
         PH_TRIPLE: begin
            case (step)
               4'd0:    u = mk(OP_MUL16, ADDR_T0, a1, b2);
               4'd1:    u = mk(OP_MUL16, ADDR_T1, a2, b1);
               4'd2:    u = mk(OP_SUB,   ADDR_T2, ADDR_T0, ADDR_T1);
               4'd3:    u = mk(OP_MUL16, ADDR_T0, a2, b0);
               4'd4:    u = mk(OP_MUL16, ADDR_T1, a0, b2);
               4'd5:    u = mk(OP_SUB,   ADDR_T3, ADDR_T0, ADDR_T1);
               4'd6:    u = mk(OP_MUL16, ADDR_T0, a0, b1);
               4'd7:    u = mk(OP_MUL16, ADDR_T1, a1, b0);
               4'd8:    u = mk(OP_SUB,   ADDR_T4, ADDR_T0, ADDR_T1);
               4'd9:    u = mk(OP_MUL16, ADDR_T0, ADDR_T2, c0);
               4'd10:   u = mk(OP_MUL16, ADDR_T1, ADDR_T3, c1);
               4'd11:   u = mk(OP_ADD,   ADDR_T0, ADDR_T0, ADDR_T1);
               4'd12:   u = mk(OP_MUL16, ADDR_T1, ADDR_T4, c2);
               default: u = mk(OP_ADD,   rd,      ADDR_T0, ADDR_T1);
            endcase
         end
         PH_COMBINE: begin
            case (step)
               4'd0:    u = mk(OP_ADD, ADDR_A1, ADDR_A1, ADDR_R2);
               4'd1:    u = mk(OP_ADD, ADDR_A1, ADDR_A1, ADDR_R3);
               4'd2:    u = mk(OP_ADD, ADDR_A2, ADDR_A2, ADDR_R5);
               default: u = mk(OP_ADD, ADDR_A2, ADDR_A2, ADDR_R6);
            endcase
         end
         PH_NEWTON: begin
            case (step)
               4'd0:    u = mk(OP_ADD,   ADDR_T0, ADDR_A3, ADDR_A3);
               4'd1:    u = mk(OP_ADD,   ADDR_T0, ADDR_T0, ADDR_A3);
               4'd2:    u = mk(OP_MUL28, ADDR_T0, ADDR_T0, ADDR_T);
               4'd3:    u = mk(OP_ADD,   ADDR_T1, ADDR_A2, ADDR_A2);
               4'd4:    u = mk(OP_ADD,   ADDR_T0, ADDR_T0, ADDR_T1);
               4'd5:    u = mk(OP_MUL28, ADDR_T0, ADDR_T0, ADDR_T);
               4'd6:    u = mk(OP_ADD,   ADDR_T0, ADDR_T0, ADDR_A1);
               4'd7:    u = mk(OP_MUL28, ADDR_T1, ADDR_A3, ADDR_T);
               4'd8:    u = mk(OP_ADD,   ADDR_T1, ADDR_T1, ADDR_A2);
               4'd9:    u = mk(OP_MUL28, ADDR_T1, ADDR_T1, ADDR_T);
               4'd10:   u = mk(OP_ADD,   ADDR_T1, ADDR_T1, ADDR_A1);
               4'd11:   u = mk(OP_MUL28, ADDR_T1, ADDR_T1, ADDR_T);
               default: u = mk(OP_ADD,   ADDR_T1, ADDR_T1, ADDR_A0);
            endcase
         end
         default: u = mk(OP_ADD, ADDR_T0, ADDR_T0, ADDR_T0);
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

### hw/rtl/ctns_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctns_ram
// generic ram, one write port and two registered read ports
// ----------------------------------------------------------------------------
module ctns_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic      [WIDTH-1:0]         rd_data_a,
   output logic      [WIDTH-1:0]         rd_data_b
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end
endmodule
`default_nettype wire

### hw/rtl/ctns_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctns_queue
// short job queue between front and back
// ----------------------------------------------------------------------------
module ctns_queue #(
   parameter int WIDTH = 608,
   parameter int DEPTH = ctns_pkg::QUEUE_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_LAST) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_LAST) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

### hw/rtl/ctns_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctns_front
// takes vertex requests, keeps vertices 0-2, forms difference vectors
// ----------------------------------------------------------------------------
module ctns_front #(
   parameter int COORD_WIDTH = ctns_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   input  wire logic [ctns_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  wire logic [1:0]                           req_tuser,
   input  wire logic                                 q_full_i,
   output logic                                      q_push_o,
   output logic [ctns_pkg::NUM_DIFF*COORD_WIDTH+ctns_pkg::TIME_W-1:0] q_data_o
);
   import ctns_pkg::*;

   localparam logic signed [48:0] CLAMP_HI = (49'sd1 <<< (COORD_WIDTH - 1)) - 49'sd1;
   localparam logic signed [48:0] CLAMP_LO = -CLAMP_HI - 49'sd1;

   logic signed [COORD_W-1:0] item_pos [3];
   logic signed [COORD_W-1:0] item_vel [3];
   logic signed [COORD_W-1:0] pos_ff [3][3];
   logic signed [COORD_W-1:0] vel_ff [3][3];
   logic                      accept;

   function automatic logic [COORD_WIDTH-1:0] csat(input logic signed [COORD_W-1:0] a,
                                                   input logic signed [COORD_W-1:0] b);
      logic signed [48:0] d;
      d = 49'(a) - 49'(b);
      if (d > CLAMP_HI) return CLAMP_HI[COORD_WIDTH-1:0];
      if (d < CLAMP_LO) return CLAMP_LO[COORD_WIDTH-1:0];
      return d[COORD_WIDTH-1:0];
   endfunction

   assign req_tready = !q_full_i;
   assign accept     = req_tvalid && req_tready;
   assign q_push_o   = accept && (req_tuser == SLOT_SOLVE);

   for (genvar ax = 0; ax < 3; ax++) begin : g_unpack
      assign item_pos[ax] = req_tdata[ax*COORD_W +: COORD_W];
      assign item_vel[ax] = req_tdata[(ax+3)*COORD_W +: COORD_W];
   end

   always_ff @(posedge clock) begin
      if (accept && (req_tuser != SLOT_SOLVE)) begin
         for (int ax = 0; ax < 3; ax++) begin
            pos_ff[req_tuser][ax] <= item_pos[ax];
            vel_ff[req_tuser][ax] <= item_vel[ax];
         end
      end
   end

   // x_k = p0 - p(k+1) and v_k = u0 - u(k+1), vertex 3 comes straight from the request
   for (genvar k = 0; k < 3; k++) begin : g_diff
      for (genvar ax = 0; ax < 3; ax++) begin : g_axis
         if (k < 2) begin : g_stored
            assign q_data_o[(k*3+ax)*COORD_WIDTH +: COORD_WIDTH] =
               csat(pos_ff[0][ax], pos_ff[k+1][ax]);
            assign q_data_o[(9+k*3+ax)*COORD_WIDTH +: COORD_WIDTH] =
               csat(vel_ff[0][ax], vel_ff[k+1][ax]);
         end else begin : g_live
            assign q_data_o[(k*3+ax)*COORD_WIDTH +: COORD_WIDTH] =
               csat(pos_ff[0][ax], item_pos[ax]);
            assign q_data_o[(9+k*3+ax)*COORD_WIDTH +: COORD_WIDTH] =
               csat(vel_ff[0][ax], item_vel[ax]);
         end
      end
   end

   assign q_data_o[NUM_DIFF*COORD_WIDTH +: TIME_W] = req_tdata[6*COORD_W +: TIME_W];
endmodule
`default_nettype wire

### hw/rtl/ctns_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ctns_back
// micro-op sequencer: cubic coefficients, newton steps, serial divider
// ----------------------------------------------------------------------------
module ctns_back #(
   parameter int COORD_WIDTH = ctns_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 q_empty_i,
   output logic                                      q_pop_o,
   input  wire logic [ctns_pkg::NUM_DIFF*COORD_WIDTH+ctns_pkg::TIME_W-1:0] q_data_i,
   input  wire logic [ctns_pkg::THR_W-1:0]           flat_threshold_i,
   input  wire logic [ctns_pkg::LIM_W-1:0]           iteration_limit_i,
   output logic                                      rsp_valid_o,
   input  wire logic                                 rsp_ready_i,
   output ctns_pkg::result_type                      rsp_result_o
);
   import ctns_pkg::*;

   back_state_type           state_ff, state_in, retire_next;
   phase_type                phase_ff, phase_in;
   logic [2:0]               tri_ff, tri_in;
   logic [3:0]               step_ff, step_in;
   logic [LIM_W-1:0]         iter_ff, iter_in, lim;
   logic [4:0]               ld_ff, ld_in;
   logic signed [TIME_W-1:0] t_ff, t_in;
   logic [63:0]              ma_ff, ma_in, mb_ff, mb_in;
   logic                     mneg_ff, mneg_in, msh_ff, msh_in;
   logic [1:0]               pp_ff, pp_in;
   logic [127:0]             acc_ff, acc_in;
   logic signed [63:0]       fd_ff, fd_in, f_ff, f_in;
   logic [63:0]              den_ff, den_in, r_ff, r_in;
   logic [34:0]              q_ff, q_in;
   logic [5:0]               nb_ff, nb_in, dcnt_ff, dcnt_in;
   logic                     qneg_ff, qneg_in;
   status_type               status_ff, status_in;
   logic                     out_valid_ff, out_valid_in;
   result_type               out_ff, out_in;

   uop_type                  uop;
   logic                     is_mul, retire, res_flat, div_big, div_ge;
   logic                     ram_we;
   logic [RF_AW-1:0]         ram_waddr;
   logic [WORD_W-1:0]        ram_wdata, rd_a, rd_b;
   logic signed [63:0]       load_word [NUM_LOAD];
   logic signed [64:0]       add_b;
   logic signed [63:0]       add_res, mul_res, res;
   logic [31:0]              pa, pb;
   logic [63:0]              pprod, mmag, n_mag;
   logic [127:0]             pterm, shr;
   logic [64:0]              r2, r_sub;
   logic signed [35:0]       qs, nt;
   logic signed [TIME_W-1:0] nt_sat;

   assign uop    = prog(phase_ff, tri_ff, step_ff);
   assign is_mul = (uop.op == OP_MUL16) || (uop.op == OP_MUL28);
   assign lim    = (iteration_limit_i > LIM_W'(MAX_ITER)) ? LIM_W'(MAX_ITER)
                                                          : iteration_limit_i;
   assign retire = ((state_ff == S_EXEC) && !is_mul) || (state_ff == S_MWR);

   for (genvar i = 0; i < NUM_DIFF; i++) begin : g_load
      assign load_word[i] = 64'($signed(q_data_i[i*COORD_WIDTH +: COORD_WIDTH]));
   end
   assign load_word[NUM_DIFF] = 64'($signed(q_data_i[NUM_DIFF*COORD_WIDTH +: TIME_W]));

   ctns_ram #(.WIDTH(WORD_W), .DEPTH(RF_DEPTH)) u_regfile (
      .clock     (clock),
      .wr_en     (ram_we),
      .wr_addr   (ram_waddr),
      .wr_data   (ram_wdata),
      .rd_addr_a (uop.sa),
      .rd_addr_b (uop.sb),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // saturating add / subtract
   assign add_b   = (uop.op == OP_SUB) ? -$signed({rd_b[63], rd_b}) : $signed({rd_b[63], rd_b});
   assign add_res = sat65($signed({rd_a[63], rd_a}) + add_b);

   // one 32x32 partial product per cycle
   assign pa    = pp_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign pb    = pp_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
   assign pprod = pa * pb;
   always_comb begin
      case (pp_ff)
         2'd0:    pterm = {64'd0, pprod};
         2'd3:    pterm = {pprod, 64'd0};
         default: pterm = {32'd0, pprod, 32'd0};
      endcase
   end
   assign shr     = msh_ff ? (acc_ff >> 28) : (acc_ff >> 16);
   assign mmag    = (|shr[127:63]) ? 64'(SMAX) : shr[63:0];
   assign mul_res = mneg_ff ? -$signed(mmag) : $signed(mmag);

   assign res      = (state_ff == S_MWR) ? mul_res : add_res;
   assign res_flat = is_flat(res, flat_threshold_i);

   // divider
   assign n_mag   = mag64(f_ff);
   assign div_big = {6'd0, n_mag} >= {mag64(fd_ff), 6'd0};
   assign r2      = {r_ff, nb_ff[5]};
   assign r_sub   = r2 - {1'b0, den_ff};
   assign div_ge  = (r2 >= {1'b0, den_ff});

   // time update
   assign qs     = qneg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
   assign nt     = 36'(t_ff) - qs;
   assign nt_sat = (nt > 36'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                   (nt < -36'sh0_8000_0000) ? 32'sh8000_0000 : nt[31:0];

   always_comb begin
      retire_next = S_FETCH;
      case (phase_ff)
         PH_COMBINE: begin
            if (step_ff == COMBINE_LAST) retire_next = S_CHK;
         end
         PH_NEWTON: begin
            if (step_ff == NEWTON_FD && res_flat) retire_next = S_DONE;
            else if (step_ff == NEWTON_LAST) retire_next = S_DIVI;
         end
         default: retire_next = S_FETCH;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (!q_empty_i) state_in = S_LOAD;
         S_LOAD:  if (ld_ff == LOAD_LAST) state_in = S_FETCH;
         S_FETCH: state_in = S_EXEC;
         S_EXEC:  state_in = is_mul ? S_MUL : retire_next;
         S_MUL:   if (pp_ff == 2'd3) state_in = S_MWR;
         S_MWR:   state_in = retire_next;
         S_CHK:   state_in = (iter_ff >= lim) ? S_DONE : S_FETCH;
         S_DIVI:  state_in = div_big ? S_UPD : S_DIV;
         S_DIV:   if (dcnt_ff == '0) state_in = S_UPD;
         S_UPD:   state_in = is_flat(f_ff, flat_threshold_i) ? S_DONE : S_CHK;
         S_DONE:  if (!out_valid_ff || rsp_ready_i) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in     = phase_ff;
      tri_in       = tri_ff;
      step_in      = step_ff;
      iter_in      = iter_ff;
      ld_in        = ld_ff;
      t_in         = t_ff;
      ma_in        = ma_ff;
      mb_in        = mb_ff;
      mneg_in      = mneg_ff;
      msh_in       = msh_ff;
      pp_in        = pp_ff;
      acc_in       = acc_ff;
      fd_in        = fd_ff;
      f_in         = f_ff;
      den_in       = den_ff;
      r_in         = r_ff;
      q_in         = q_ff;
      nb_in        = nb_ff;
      dcnt_in      = dcnt_ff;
      qneg_in      = qneg_ff;
      status_in    = status_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_ready_i;
      q_pop_o      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = uop.dst;
      ram_wdata    = res;
      case (state_ff)
         S_IDLE: ld_in = '0;
         S_LOAD: begin
            ram_we    = 1'b1;
            ram_waddr = ld_ff;
            ram_wdata = load_word[ld_ff];
            if (ld_ff == LOAD_LAST) begin
               q_pop_o  = 1'b1;
               t_in     = load_word[NUM_DIFF][TIME_W-1:0];
               phase_in = PH_TRIPLE;
               tri_in   = '0;
               step_in  = '0;
               iter_in  = '0;
            end else begin
               ld_in = ld_ff + 1'b1;
            end
         end
         S_EXEC: begin
            if (is_mul) begin
               ma_in   = mag64(rd_a);
               mb_in   = mag64(rd_b);
               mneg_in = rd_a[63] ^ rd_b[63];
               msh_in  = (uop.op == OP_MUL28);
               pp_in   = '0;
               acc_in  = '0;
            end
         end
         S_MUL: begin
            acc_in = acc_ff + pterm;
            pp_in  = pp_ff + 1'b1;
         end
         S_CHK: begin
            step_in = '0;
            if (iter_ff >= lim) status_in = ST_LIMIT;
         end
         S_DIVI: begin
            den_in  = mag64(fd_ff);
            qneg_in = f_ff[63] ^ fd_ff[63];
            r_in    = {6'd0, n_mag[63:6]};
            nb_in   = n_mag[5:0];
            dcnt_in = DIV_STEPS;
            q_in    = div_big ? (35'd1 << 34) : '0;
         end
         S_DIV: begin
            r_in    = div_ge ? r_sub[63:0] : r2[63:0];
            q_in    = {q_ff[33:0], div_ge};
            nb_in   = {nb_ff[4:0], 1'b0};
            dcnt_in = dcnt_ff - 1'b1;
         end
         S_UPD: begin
            t_in      = nt_sat;
            ram_we    = 1'b1;
            ram_waddr = ADDR_T;
            ram_wdata = 64'(nt_sat);
            if (is_flat(f_ff, flat_threshold_i)) status_in = ST_CONVERGED;
            else iter_in = iter_ff + 1'b1;
         end
         S_DONE: begin
            if (!out_valid_ff || rsp_ready_i) begin
               out_valid_in        = 1'b1;
               out_in.hit          = (status_ff == ST_CONVERGED);
               out_in.status       = status_ff;
               out_in.refined_time = t_ff;
            end
         end
         default: ;
      endcase
      if (retire) begin
         ram_we = 1'b1;
         case (phase_ff)
            PH_TRIPLE: begin
               if (step_ff == TRIPLE_LAST) begin
                  step_in = '0;
                  if (tri_ff == TRIPLE_MAX) phase_in = PH_COMBINE;
                  else tri_in = tri_ff + 1'b1;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
            PH_COMBINE: begin
               if (step_ff == COMBINE_LAST) phase_in = PH_NEWTON;
               else step_in = step_ff + 1'b1;
            end
            default: begin
               if (step_ff == NEWTON_FD) begin
                  fd_in = res;
                  if (res_flat) status_in = ST_FLAT;
               end
               if (step_ff == NEWTON_LAST) f_in = res;
               else step_in = step_ff + 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      phase_ff  <= phase_in;
      tri_ff    <= tri_in;
      step_ff   <= step_in;
      iter_ff   <= iter_in;
      ld_ff     <= ld_in;
      t_ff      <= t_in;
      ma_ff     <= ma_in;
      mb_ff     <= mb_in;
      mneg_ff   <= mneg_in;
      msh_ff    <= msh_in;
      pp_ff     <= pp_in;
      acc_ff    <= acc_in;
      fd_ff     <= fd_in;
      f_ff      <= f_in;
      den_ff    <= den_in;
      r_ff      <= r_in;
      q_ff      <= q_in;
      nb_ff     <= nb_in;
      dcnt_ff   <= dcnt_in;
      qneg_ff   <= qneg_in;
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   assign rsp_valid_o  = out_valid_ff;
   assign rsp_result_o = out_ff;
endmodule
`default_nettype wire

### hw/rtl/coplanarity_time_newton_solver_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// coplanarity_time_newton_solver_unit
// newton solver for the time at which four moving points become coplanar
// ----------------------------------------------------------------------------
// Send four vertex requests (slot in req_tuser); slots 0-2 are only stored
// and give no response, slot 3 starts a solve and gives exactly one response.
// The front takes a request of any slot every cycle while its two-entry job
// queue has room; once the queue is full it holds off every request. The back
// works one job at a time through a single 64-bit register file and one
// multiplier that builds each 64x64 product from four 32x32 partial
// products: loading a job writes 19 words, then it forms the cubic
// coefficients and runs newton steps, each with up to five products, eight
// adds and a bit-serial divide. The result register lets the next job
// start while the previous response waits.
// ----------------------------------------------------------------------------
module coplanarity_time_newton_solver_unit #(
   parameter int COORD_WIDTH = ctns_pkg::COORD_WIDTH_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request: tdata = pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, start_time
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [ctns_pkg::REQ_DATA_W-1:0]     req_tdata,
   // tuser = vertex_slot
   input  wire logic [1:0]                          req_tuser,
   // response: tdata = hit, status, refined_time, zero padding
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [ctns_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // register writes
   input  wire logic                                csr_we,
   input  wire logic [ctns_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [ctns_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ctns_pkg::*;

   localparam int JOB_W = NUM_DIFF * COORD_WIDTH + TIME_W;

   logic [THR_W-1:0] flat_threshold_ff;
   logic [LIM_W-1:0] iteration_limit_ff;
   logic             q_push, q_full, q_pop, q_empty;
   logic [JOB_W-1:0] push_job, pop_job;
   result_type       rsp_result;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         flat_threshold_ff  <= FLAT_THRESHOLD_RST;
         iteration_limit_ff <= ITERATION_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FLAT_THRESHOLD:  flat_threshold_ff  <= csr_wdata[THR_W-1:0];
            CSR_ITERATION_LIMIT: iteration_limit_ff <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   // front: vertex store and difference vectors
   ctns_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock      (clock),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full_i   (q_full),
      .q_push_o   (q_push),
      .q_data_o   (push_job)
   );

   // job queue decouples the two sides
   ctns_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_job),
      .empty     (q_empty)
   );

   // back: coefficient and newton sequencer
   ctns_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_empty_i         (q_empty),
      .q_pop_o           (q_pop),
      .q_data_i          (pop_job),
      .flat_threshold_i  (flat_threshold_ff),
      .iteration_limit_i (iteration_limit_ff),
      .rsp_valid_o       (rsp_tvalid),
      .rsp_ready_i       (rsp_tready),
      .rsp_result_o      (rsp_result)
   );

   // hit in bit 0, status above it, then refined time
   assign rsp_tdata = {5'd0, rsp_result.refined_time, rsp_result.status, rsp_result.hit};

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("job queue popped while empty");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("job queue pushed while full");
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_result.hit == (rsp_result.status == ST_CONVERGED)))
      else $error("hit does not match status");
`endif
endmodule
`default_nettype wire
